// File: src/rcom_pkg.sv
// Shared constants, codes and control structs for the channel override mixer.
package rcom_pkg;

  localparam int NUM_CHANNELS   = 16;
  localparam int CHANNEL_MIN    = 172;
  localparam int CHANNEL_MAX    = 1811;
  localparam int CHANNEL_CENTER = 992;
  localparam int THROTTLE_INDEX = 2;
  localparam int NUM_LEVELS     = 4;

  localparam int ACT_W = 3;
  localparam int CH_W  = 4;
  localparam int VAL_W = 11;
  localparam int LVL_W = 2;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Mix arithmetic widths
  localparam int CH_RANGE    = CHANNEL_MAX - CHANNEL_MIN;
  localparam int RANGE_W     = $clog2(CH_RANGE + 1);
  localparam int D_W         = VAL_W + 2;
  localparam int PROD_W      = 2 * D_W;
  localparam int OR_W        = VAL_W + RANGE_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int NUM_W       = VAL_W + RANGE_W + 1;
  localparam int RECIP_SHIFT = NUM_W + RANGE_W;
  localparam int RECIP_W     = NUM_W + 2;
  localparam int QP_W        = NUM_W + RECIP_W;
  localparam int Q_W         = QP_W - RECIP_SHIFT;

  // Rounded-up reciprocal of the range; exact floor division for NUM_W-bit dividends
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(CH_RANGE) - 64'd1) / 64'(CH_RANGE);

  typedef enum logic [ACT_W-1:0] {
    ACT_SET_VALUE    = 3'd0,
    ACT_SET_OVERRIDE = 3'd1,
    ACT_CLEAR        = 3'd2,
    ACT_READ_RAW     = 3'd3,
    ACT_READ_MIX     = 3'd4,
    ACT_RESET        = 3'd5
  } act_t;

  typedef struct packed {
    logic cap_in;
    logic exec;
    logic step1;
    logic step2;
    logic step3;
    logic step4;
    logic push;
  } rcom_cmd_t;

  typedef struct packed {
    logic is_read;
    logic use_mix;
    logic out_free;
  } rcom_sts_t;

endpackage

// File: src/rcom_ctrl.sv
// Controller state machine: sequences accept, execute, mix steps and result push.
module rcom_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rcom_pkg::rcom_sts_t  sts,
  output rcom_pkg::rcom_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_MIX1 = 7'b0000100,
    S_MIX2 = 7'b0001000,
    S_MIX3 = 7'b0010000,
    S_MIX4 = 7'b0100000,
    S_PUSH = 7'b1000000
  } rcom_state_t;

  rcom_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.cap_in = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.is_read) begin
          state_nxt = S_IDLE;
        end else if (sts.use_mix) begin
          state_nxt = S_MIX1;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_MIX1: begin
        cmd.step1 = 1'b1;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        cmd.step2 = 1'b1;
        state_nxt = S_MIX3;
      end
      S_MIX3: begin
        cmd.step3 = 1'b1;
        state_nxt = S_MIX4;
      end
      S_MIX4: begin
        cmd.step4 = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/rcom_dp.sv
// Datapath: channel tables, request register, mix arithmetic and output register.
module rcom_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcom_pkg::rcom_cmd_t           cmd,
  output rcom_pkg::rcom_sts_t           sts,
  input  logic [rcom_pkg::ACT_W-1:0]    in_action,
  input  logic [rcom_pkg::CH_W-1:0]     in_channel,
  input  logic [rcom_pkg::VAL_W-1:0]    in_value,
  input  logic [rcom_pkg::LVL_W-1:0]    in_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcom_pkg::VAL_W-1:0]    out_read_value,
  output logic                          out_overridden
);

  localparam int NCH = rcom_pkg::NUM_CHANNELS;
  localparam int VW  = rcom_pkg::VAL_W;
  localparam int LW  = rcom_pkg::LVL_W;
  localparam int DW  = rcom_pkg::D_W;

  localparam logic signed [DW-1:0] D_OFS  = DW'(rcom_pkg::CHANNEL_MIN + rcom_pkg::CHANNEL_MAX);
  localparam logic signed [DW-1:0] RNG_S  = DW'(rcom_pkg::CH_RANGE);
  localparam logic signed [DW-1:0] CMAX_S = DW'(rcom_pkg::CHANNEL_MAX);
  localparam logic signed [DW-1:0] CMIN_S = DW'(rcom_pkg::CHANNEL_MIN);
  localparam logic [rcom_pkg::RECIP_W-1:0] RECIP_C = rcom_pkg::RECIP_W'(rcom_pkg::RECIP);
  localparam logic [rcom_pkg::Q_W-1:0] Q_MIN = rcom_pkg::Q_W'(rcom_pkg::CHANNEL_MIN);
  localparam logic [rcom_pkg::Q_W-1:0] Q_MAX = rcom_pkg::Q_W'(rcom_pkg::CHANNEL_MAX);

  function automatic logic [VW-1:0] pilot_rst(input int idx);
    logic [VW-1:0] v;
    v = (idx == rcom_pkg::THROTTLE_INDEX) ? VW'(rcom_pkg::CHANNEL_MIN)
                                          : VW'(rcom_pkg::CHANNEL_CENTER);
    return v;
  endfunction

  // Request register
  logic [rcom_pkg::ACT_W-1:0] act_r;
  logic [rcom_pkg::CH_W-1:0]  ch_r;
  logic [VW-1:0]              val_r;
  logic [LW-1:0]              lvl_r;
  logic [LW-1:0]              lvl_sat;

  // Channel tables
  logic [VW-1:0] pilot_r   [NCH];
  logic [VW-1:0] ovr_val_r [NCH];
  logic [LW-1:0] ovr_lvl_r [NCH];
  logic [VW-1:0] pilot_nxt   [NCH];
  logic [VW-1:0] ovr_val_nxt [NCH];
  logic [LW-1:0] ovr_lvl_nxt [NCH];

  logic                        ch_ok;
  logic [rcom_pkg::CH_IDX_W-1:0] ch_idx;

  // Read operands and mix pipeline
  logic [VW-1:0] rd_pilot_r;
  logic [VW-1:0] rd_ovr_r;
  logic          rd_ovrd_r;
  logic          mix_sel_r;

  logic signed [DW-1:0] d_raw, d_clamp, k_val, d_r, k_r;
  logic [rcom_pkg::OR_W-1:0]          or_r;
  logic signed [rcom_pkg::PROD_W-1:0] prod_r;
  logic signed [rcom_pkg::SUM_W-1:0]  sum_s;
  logic [rcom_pkg::NUM_W-1:0]         num_r;
  logic [rcom_pkg::QP_W-1:0]          qp_r;
  logic [rcom_pkg::Q_W-1:0]           q_val;
  logic [VW-1:0]                      mix_val;

  // Output register
  logic          out_valid_r;
  logic [VW-1:0] out_val_r;
  logic          out_ovrd_r;

  assign lvl_sat = (32'(in_level) > rcom_pkg::NUM_LEVELS - 1) ? LW'(rcom_pkg::NUM_LEVELS - 1)
                                                               : in_level;
  assign ch_ok  = (32'(ch_r) < NCH);
  assign ch_idx = ch_r[rcom_pkg::CH_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      act_r <= in_action;
      ch_r  <= in_channel;
      val_r <= in_value;
      lvl_r <= lvl_sat;
    end
  end

  assign sts.is_read  = (act_r == rcom_pkg::ACT_READ_RAW) || (act_r == rcom_pkg::ACT_READ_MIX);
  assign sts.use_mix  = (act_r == rcom_pkg::ACT_READ_MIX) && ch_ok && (ovr_lvl_r[ch_idx] != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    pilot_nxt   = pilot_r;
    ovr_val_nxt = ovr_val_r;
    ovr_lvl_nxt = ovr_lvl_r;
    if (cmd.exec) begin
      unique case (act_r)
        rcom_pkg::ACT_SET_VALUE: begin
          if (ch_ok) begin
            pilot_nxt[ch_idx] = val_r;
          end
        end
        rcom_pkg::ACT_SET_OVERRIDE: begin
          if (ch_ok && (ovr_lvl_r[ch_idx] <= lvl_r)) begin
            ovr_val_nxt[ch_idx] = val_r;
            ovr_lvl_nxt[ch_idx] = lvl_r;
          end
        end
        rcom_pkg::ACT_CLEAR: begin
          for (int i = 0; i < NCH; i++) begin
            if (ovr_lvl_r[i] <= lvl_r) begin
              ovr_val_nxt[i] = '0;
              ovr_lvl_nxt[i] = '0;
            end
          end
        end
        rcom_pkg::ACT_RESET: begin
          for (int i = 0; i < NCH; i++) begin
            pilot_nxt[i]   = pilot_rst(i);
            ovr_val_nxt[i] = '0;
            ovr_lvl_nxt[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        pilot_r[i]   <= pilot_rst(i);
        ovr_val_r[i] <= '0;
        ovr_lvl_r[i] <= '0;
      end
    end else begin
      pilot_r   <= pilot_nxt;
      ovr_val_r <= ovr_val_nxt;
      ovr_lvl_r <= ovr_lvl_nxt;
    end
  end

  // Capture read operands
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_pilot_r <= ch_ok ? pilot_r[ch_idx] : '0;
      rd_ovr_r   <= ovr_val_r[ch_idx];
      rd_ovrd_r  <= ch_ok && (ovr_lvl_r[ch_idx] != '0);
      mix_sel_r  <= sts.use_mix;
    end
  end

  // Step 1: stick factor numerator, clamped, and the span it scales
  always_comb begin
    d_raw = $signed({1'b0, rd_pilot_r, 1'b0}) - D_OFS;
    if (d_raw > RNG_S) begin
      d_clamp = RNG_S;
    end else if (d_raw < -RNG_S) begin
      d_clamp = -RNG_S;
    end else begin
      d_clamp = d_raw;
    end
    if (d_clamp > 0) begin
      k_val = CMAX_S - $signed({2'b00, rd_ovr_r});
    end else begin
      k_val = $signed({2'b00, rd_ovr_r}) - CMIN_S;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step1) begin
      d_r  <= d_clamp;
      k_r  <= k_val;
      or_r <= rcom_pkg::OR_W'(rd_ovr_r) * rcom_pkg::OR_W'(rcom_pkg::CH_RANGE);
    end
  end

  // Step 2: scaled offset
  always_ff @(posedge clk) begin
    if (cmd.step2) begin
      prod_r <= rcom_pkg::PROD_W'(d_r) * rcom_pkg::PROD_W'(k_r);
    end
  end

  // Step 3: numerator, floored at zero
  assign sum_s = $signed({{(rcom_pkg::SUM_W - rcom_pkg::OR_W){1'b0}}, or_r})
               + rcom_pkg::SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.step3) begin
      num_r <= sum_s[rcom_pkg::SUM_W-1] ? '0 : sum_s[rcom_pkg::NUM_W-1:0];
    end
  end

  // Step 4: divide by the range through the reciprocal
  always_ff @(posedge clk) begin
    if (cmd.step4) begin
      qp_r <= rcom_pkg::QP_W'(num_r) * rcom_pkg::QP_W'(RECIP_C);
    end
  end

  always_comb begin
    q_val = qp_r[rcom_pkg::QP_W-1:rcom_pkg::RECIP_SHIFT];
    if (q_val < Q_MIN) begin
      mix_val = VW'(Q_MIN);
    end else if (q_val > Q_MAX) begin
      mix_val = VW'(Q_MAX);
    end else begin
      mix_val = q_val[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_val_r  <= mix_sel_r ? mix_val : rd_pilot_r;
      out_ovrd_r <= rd_ovrd_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_overridden = out_ovrd_r;

endmodule

// File: src/rc_channel_override_mixer_unit.sv
// Top level of the radio-control channel override mixer.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------------------
//   request  | in        | in_valid / in_ready  | in_action, in_channel, in_value, in_level
//   result   | out       | out_valid/ out_ready | out_read_value, out_overridden
//
// One request is worked at a time. Set value, set override, clear and reset pass
// through accept and execute. A raw read adds a push step; a mixed read of an
// overridden channel also runs the four-step multiply/reciprocal-divide sequence.
// A finished result sits in the output register; new requests are accepted while
// it waits, and a later read holds in its push step until the register frees.
// rst_n is synchronous, active low, and restores all channel tables to their
// power-up values (center, throttle at minimum, no overrides).
module rc_channel_override_mixer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rcom_pkg::ACT_W-1:0]    in_action,
  input  logic [rcom_pkg::CH_W-1:0]     in_channel,
  input  logic [rcom_pkg::VAL_W-1:0]    in_value,
  input  logic [rcom_pkg::LVL_W-1:0]    in_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcom_pkg::VAL_W-1:0]    out_read_value,
  output logic                          out_overridden
);

  // command and status between the sequencer and the datapath
  rcom_pkg::rcom_cmd_t cmd;
  rcom_pkg::rcom_sts_t sts;

  // sequence each request: accept, execute, then for reads optional mix steps and a result push
  rcom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold channel tables, do the mix arithmetic, own the output register
  rcom_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_channel     (in_channel),
    .in_value       (in_value),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_overridden (out_overridden)
  );

endmodule

// File: bench/tb_rc_channel_override_mixer_unit.sv
// Self-checking testbench for the radio-control channel override mixer.
module tb_rc_channel_override_mixer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Spare action codes: the block must swallow these without a result.
  localparam logic [rcom_pkg::ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [rcom_pkg::ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  // Cycles without any accepted request or result before the run is declared hung.
  localparam int IDLE_LIMIT      = 4000;
  // Length of the forced receiver hold-off used to back the block up.
  localparam int HOLD_OFF_CYCLES = 300;
  // Quiet cycles after the last result.
  localparam int SETTLE_CYCLES   = 20;
  localparam int PHASE_ITEMS     = 330;

  typedef struct packed {
    logic [rcom_pkg::ACT_W-1:0] action;
    logic [rcom_pkg::CH_W-1:0]  channel;
    logic [rcom_pkg::VAL_W-1:0] value;
    logic [rcom_pkg::LVL_W-1:0] level;
  } mix_req_t;

  typedef struct packed {
    logic [rcom_pkg::VAL_W-1:0] read_value;
    logic                       overridden;
  } read_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [rcom_pkg::ACT_W-1:0] in_action = '0;
  logic [rcom_pkg::CH_W-1:0]  in_channel = '0;
  logic [rcom_pkg::VAL_W-1:0] in_value = '0;
  logic [rcom_pkg::LVL_W-1:0] in_level = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [rcom_pkg::VAL_W-1:0] out_read_value;
  logic                       out_overridden;

  rc_channel_override_mixer_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_channel     (in_channel),
    .in_value       (in_value),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_overridden (out_overridden)
  );

  // Shadow copy of the channel tables, advanced once per accepted request.
  logic [rcom_pkg::VAL_W-1:0] stick_tbl   [rcom_pkg::NUM_CHANNELS];
  logic [rcom_pkg::VAL_W-1:0] ovr_val_tbl [rcom_pkg::NUM_CHANNELS];
  logic [rcom_pkg::LVL_W-1:0] ovr_lvl_tbl [rcom_pkg::NUM_CHANNELS];

  mix_req_t     pending_requests [$];  // requests waiting for the driver
  read_result_t read_expect      [$];  // read results still owed by the block

  mix_req_t     next_req;
  mix_req_t     taken_req;
  read_result_t taken_result;
  read_result_t oldest_read;
  bit           taken_has_result;
  bit           req_fire = 1'b0;
  int           requests_queued = 0;
  int           requests_taken = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_request = 1'b0;
  int           hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Put every channel back at its power-up position: sticks centered, throttle low.
  task automatic restore_tables();
    int i;
    for (i = 0; i < rcom_pkg::NUM_CHANNELS; i++) begin
      stick_tbl[i]   = rcom_pkg::VAL_W'(rcom_pkg::CHANNEL_CENTER);
      ovr_val_tbl[i] = '0;
      ovr_lvl_tbl[i] = '0;
    end
    if (rcom_pkg::THROTTLE_INDEX < rcom_pkg::NUM_CHANNELS)
      stick_tbl[rcom_pkg::THROTTLE_INDEX] = rcom_pkg::VAL_W'(rcom_pkg::CHANNEL_MIN);
  endtask

  // Blend the override toward an end stop by the stick deflection, floor, then clamp.
  function automatic logic [rcom_pkg::VAL_W-1:0] mixed_position(
      logic [rcom_pkg::VAL_W-1:0] stick, logic [rcom_pkg::VAL_W-1:0] ovr);
    longint span;
    longint defl;
    longint num;
    longint res;
    span = longint'(rcom_pkg::CHANNEL_MAX) - longint'(rcom_pkg::CHANNEL_MIN);
    if (span <= 0) return rcom_pkg::VAL_W'(rcom_pkg::CHANNEL_MIN);
    defl = 2 * (longint'(stick) - longint'(rcom_pkg::CHANNEL_MIN)) - span;
    if (defl > span)  defl = span;
    if (defl < -span) defl = -span;
    if (defl > 0)
      num = longint'(ovr) * span + (longint'(rcom_pkg::CHANNEL_MAX) - longint'(ovr)) * defl;
    else
      num = longint'(ovr) * span + (longint'(ovr) - longint'(rcom_pkg::CHANNEL_MIN)) * defl;
    if (num < 0) num = 0;
    res = num / span;
    if (res < rcom_pkg::CHANNEL_MIN) res = rcom_pkg::CHANNEL_MIN;
    if (res > rcom_pkg::CHANNEL_MAX) res = rcom_pkg::CHANNEL_MAX;
    return res[rcom_pkg::VAL_W-1:0];
  endfunction

  // Apply one request to the shadow tables; report the read result it owes, if any.
  task automatic apply_request(input mix_req_t r, output bit has_out,
                               output read_result_t res);
    int i;
    int lvl;
    bit ch_ok;
    lvl = int'(r.level);
    if (lvl > rcom_pkg::NUM_LEVELS - 1) lvl = rcom_pkg::NUM_LEVELS - 1;
    ch_ok = int'(r.channel) < rcom_pkg::NUM_CHANNELS;
    has_out = 1'b0;
    res = '0;
    case (r.action)
      rcom_pkg::ACT_SET_VALUE: begin
        if (ch_ok) stick_tbl[r.channel] = r.value;
      end
      rcom_pkg::ACT_SET_OVERRIDE: begin
        if (ch_ok && int'(ovr_lvl_tbl[r.channel]) <= lvl) begin
          ovr_val_tbl[r.channel] = r.value;
          ovr_lvl_tbl[r.channel] = rcom_pkg::LVL_W'(lvl);
        end
      end
      rcom_pkg::ACT_CLEAR: begin
        for (i = 0; i < rcom_pkg::NUM_CHANNELS; i++) begin
          if (int'(ovr_lvl_tbl[i]) <= lvl) begin
            ovr_val_tbl[i] = '0;
            ovr_lvl_tbl[i] = '0;
          end
        end
      end
      rcom_pkg::ACT_READ_RAW, rcom_pkg::ACT_READ_MIX: begin
        has_out = 1'b1;
        if (ch_ok) begin
          if (r.action == rcom_pkg::ACT_READ_MIX && ovr_lvl_tbl[r.channel] != '0)
            res.read_value = mixed_position(stick_tbl[r.channel], ovr_val_tbl[r.channel]);
          else
            res.read_value = stick_tbl[r.channel];
          res.overridden = ovr_lvl_tbl[r.channel] != '0;
        end
      end
      rcom_pkg::ACT_RESET: begin
        restore_tables();
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic queue_request(input logic [rcom_pkg::ACT_W-1:0] act,
                               input logic [rcom_pkg::CH_W-1:0] ch,
                               input logic [rcom_pkg::VAL_W-1:0] val,
                               input logic [rcom_pkg::LVL_W-1:0] lvl);
    pending_requests.push_back('{act, ch, val, lvl});
    requests_queued++;
  endtask

  // Favor the end stops, the mix breakpoints and the center, then anything.
  function automatic logic [rcom_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return rcom_pkg::VAL_W'(rcom_pkg::CHANNEL_MIN + $urandom_range(0, 6) - 3);
      3:       return rcom_pkg::VAL_W'(rcom_pkg::CHANNEL_MAX + $urandom_range(0, 6) - 3);
      4:       return rcom_pkg::VAL_W'(rcom_pkg::CHANNEL_CENTER + $urandom_range(0, 6) - 3);
      default: return rcom_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Hit the end stops, level priority, clearing, spare codes and a full reset.
  task automatic queue_directed();
    queue_request(rcom_pkg::ACT_READ_RAW,     4'd0,  11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_READ_RAW,     4'd2,  11'd2047, 2'd3);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd15, 11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_SET_VALUE,    4'd0,  11'd2047, 2'd0);
    queue_request(rcom_pkg::ACT_SET_VALUE,    4'd1,  11'd0,    2'd3);
    queue_request(rcom_pkg::ACT_SET_OVERRIDE, 4'd0,  11'd0,    2'd3);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd0,  11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_SET_OVERRIDE, 4'd1,  11'd2047, 2'd1);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd1,  11'd0,    2'd0);
    // lower level must bounce off the stored one
    queue_request(rcom_pkg::ACT_SET_OVERRIDE, 4'd0,  11'd1500, 2'd2);
    queue_request(rcom_pkg::ACT_READ_RAW,     4'd0,  11'd0,    2'd0);
    // equal level wins
    queue_request(rcom_pkg::ACT_SET_OVERRIDE, 4'd1,  11'd1000, 2'd1);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd1,  11'd0,    2'd0);
    // blend lands above the top stop and must clamp down
    queue_request(rcom_pkg::ACT_SET_OVERRIDE, 4'd15, 11'd2047, 2'd3);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd15, 11'd0,    2'd0);
    // blend lands below the bottom stop and must clamp up
    queue_request(rcom_pkg::ACT_SET_VALUE,    4'd14, 11'd991,  2'd0);
    queue_request(rcom_pkg::ACT_SET_OVERRIDE, 4'd14, 11'd0,    2'd2);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd14, 11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_CLEAR,        4'd0,  11'd0,    2'd1);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd1,  11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd0,  11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_CLEAR,        4'd0,  11'd0,    2'd0);
    queue_request(ACT_UNUSED_LO,              4'd0,  11'd2047, 2'd3);
    queue_request(ACT_UNUSED_HI,              4'd15, 11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_RESET,        4'd0,  11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_READ_RAW,     4'd2,  11'd0,    2'd0);
    queue_request(rcom_pkg::ACT_READ_MIX,     4'd0,  11'd0,    2'd0);
  endtask

  // Mostly set-stick / set-override / mixed-read chains on one channel, plus noise.
  task automatic queue_random_traffic(input int target);
    int made;
    int pick;
    logic [rcom_pkg::CH_W-1:0] ch;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      ch = rcom_pkg::CH_W'($urandom_range(0, (1 << rcom_pkg::CH_W) - 1));
      if (pick < 55) begin
        queue_request(rcom_pkg::ACT_SET_VALUE, ch, pick_value(),
                      rcom_pkg::LVL_W'($urandom));
        queue_request(rcom_pkg::ACT_SET_OVERRIDE, ch, pick_value(),
                      rcom_pkg::LVL_W'($urandom));
        queue_request(rcom_pkg::ACT_READ_MIX, ch, rcom_pkg::VAL_W'($urandom),
                      rcom_pkg::LVL_W'($urandom));
        made += 3;
        if ($urandom_range(0, 3) == 0) begin
          queue_request(rcom_pkg::ACT_READ_RAW, ch, rcom_pkg::VAL_W'($urandom),
                        rcom_pkg::LVL_W'($urandom));
          made++;
        end
      end else if (pick < 96) begin
        case ($urandom_range(0, 9))
          0, 1:    queue_request(rcom_pkg::ACT_SET_VALUE, ch, pick_value(),
                                 rcom_pkg::LVL_W'($urandom));
          2, 3:    queue_request(rcom_pkg::ACT_SET_OVERRIDE, ch, pick_value(),
                                 rcom_pkg::LVL_W'($urandom));
          4:       queue_request(rcom_pkg::ACT_CLEAR, ch, rcom_pkg::VAL_W'($urandom),
                                 rcom_pkg::LVL_W'($urandom));
          5, 6:    queue_request(rcom_pkg::ACT_READ_RAW, ch, rcom_pkg::VAL_W'($urandom),
                                 rcom_pkg::LVL_W'($urandom));
          default: queue_request(rcom_pkg::ACT_READ_MIX, ch, rcom_pkg::VAL_W'($urandom),
                                 rcom_pkg::LVL_W'($urandom));
        endcase
        made++;
      end else if (pick < 98) begin
        queue_request(rcom_pkg::ACT_RESET, ch, rcom_pkg::VAL_W'($urandom),
                      rcom_pkg::LVL_W'($urandom));
        made++;
      end else begin
        // spare codes are ignored by the block, so leave them out of the count
        queue_request($urandom_range(0, 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO, ch,
                      rcom_pkg::VAL_W'($urandom), rcom_pkg::LVL_W'($urandom));
      end
    end
  endtask

  // Hold until every queued request is in and every read has come back.
  task automatic wait_drained();
    while (requests_taken != requests_queued || read_expect.size() != 0) @(negedge clk);
  endtask

  // Driver: advance to the next request only once the current one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        in_valid   <= 1'b1;
        in_action  <= next_req.action;
        in_channel <= next_req.channel;
        in_value   <= next_req.value;
        in_level   <= next_req.level;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on demand to back the block up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
    end
  end

  // Monitor: check results against the oldest owed read, then predict new requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_fire = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (read_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected result read_value=%0d overridden=%0b",
                                  out_read_value, out_overridden));
        end else begin
          oldest_read = read_expect.pop_front();
          if (out_read_value !== oldest_read.read_value)
            flag_mismatch($sformatf("read_value got %0d want %0d",
                                    out_read_value, oldest_read.read_value));
          if (out_overridden !== oldest_read.overridden)
            flag_mismatch($sformatf("overridden got %0b want %0b",
                                    out_overridden, oldest_read.overridden));
        end
      end
      req_fire = in_valid && in_ready;
      if (req_fire) begin
        taken_req = '{in_action, in_channel, in_value, in_level};
        apply_request(taken_req, taken_has_result, taken_result);
        if (taken_has_result) read_expect.push_back(taken_result);
        requests_taken++;
      end
      // Watchdog: drop the run if neither side moves for too long.
      if (req_fire || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[rc_channel_override_mixer_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int k;
    logic [rcom_pkg::CH_W-1:0] ch;
    restore_tables();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    wait_drained();

    // Phases: free-running, sender gaps, receiver stalls, then light gaps on both.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 52 : (phase == 3) ? 7 : 0;
      recv_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 7 : 0;
      if (phase == 3) begin
        // Hold the receiver off while a read-heavy burst keeps the sender busy.
        hold_request = 1'b1;
        for (k = 0; k < 8; k++) begin
          ch = rcom_pkg::CH_W'($urandom);
          queue_request(rcom_pkg::ACT_SET_OVERRIDE, ch, pick_value(), 2'd3);
          queue_request(rcom_pkg::ACT_READ_MIX, ch, rcom_pkg::VAL_W'($urandom),
                        rcom_pkg::LVL_W'($urandom));
          queue_request(rcom_pkg::ACT_READ_RAW, ch, rcom_pkg::VAL_W'($urandom),
                        rcom_pkg::LVL_W'($urandom));
        end
      end
      queue_random_traffic(PHASE_ITEMS);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[rc_channel_override_mixer_unit] OK");
    end else begin
      $display("[rc_channel_override_mixer_unit] ERROR");
    end
    $finish;
  end

endmodule
